/* hw/rtl/tgc_pkg.sv */
`default_nettype none
package tgc_pkg;

  localparam int FeatureCount = 8;
  localparam int FractionBits = 16;
  localparam int SigDepth = 256;
  localparam int Slots = 8;
  localparam int ProdShift = 2 * FractionBits;
  localparam int IdxShift = FractionBits + 3 - $clog2(SigDepth);
  localparam int IdxW = $clog2(SigDepth);

  localparam logic [46:0] AccMax = {47{1'b1}};
  localparam logic signed [47:0] FloorReset = -48'sd15090221;

  localparam logic [1:0] RegReady = 2'd0;
  localparam logic [1:0] RegBiasNoise = 2'd1;
  localparam logic [1:0] RegBiasSignal = 2'd2;
  localparam logic [1:0] RegLogFloor = 2'd3;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdClassify = 1'b1;

  typedef logic [FeatureCount-1:0][31:0] word_vec_t;
  typedef logic [FeatureCount-1:0][39:0] ivar_vec_t;
  typedef logic [15:0] sig_tab_t [SigDepth];

  typedef struct packed {
    logic ready;
    logic signed [47:0] bias_noise;
    logic signed [47:0] bias_signal;
    logic signed [47:0] log_floor;
  } cfg_t;

  function automatic logic [46:0] sat_add(input logic [46:0] a, input logic [46:0] b);
    logic [47:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[47] ? AccMax : s[46:0];
  endfunction

  // restoring long division, only used while building the constant table
  function automatic logic [63:0] div_const(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig();
    sig_tab_t tab;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] v;
    logic [127:0] p;
    logic signed [64:0] sum;
    h = div_const(64'd1 << 35, 64'(SigDepth));
    term = 64'd1 << 32;
    sum = 65'sd1 <<< 32;
    for (int n = 1; n <= 10; n++) begin
      p = 128'(term) * 128'(h);
      term = div_const(p[95:32], 64'(n));
      if ((n & 1) == 1) sum = sum - $signed({1'b0, term});
      else sum = sum + $signed({1'b0, term});
    end
    r = sum[63:0];
    e = 64'd1 << 32;
    for (int i = 0; i < SigDepth; i++) begin
      v = div_const(64'd1 << 48, (64'd1 << 32) + e);
      tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      p = 128'(e) * 128'(r);
      e = p[95:32];
    end
    return tab;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/two_class_gaussian_classifier.sv */
// two-class diagonal gaussian classifier, noise versus signal
// input channel: in_valid/in_stall; command load writes one mean or inverse
//   variance word, command classify scores the eight features
// result channel: out_valid/out_stall; one transaction per classify item,
//   none per load item
// pipeline: 9 register stages (diff, square, two partial products, term,
//   three adder tree levels, score, compare and sigmoid table)
// throughput: one item per cycle unless a stall holds the pipeline; every
//   stage is a register stage of a single global pipeline enable
// stall: when a result waits with out_stall high, the whole pipeline holds
//   and in_stall rises in the same cycle; nothing is lost or repeated
// reset: registers return to defaults (not ready, floor at log 1e-100),
//   pipeline empties; parameter tables keep contents and must be loaded
// configuration: apb port, 64-bit registers at 8*index, write only when idle
`default_nettype none
module two_class_gaussian_classifier import tgc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_command,
  input  wire logic [4:0]         in_param_index,
  input  wire logic [39:0]        in_param_value,
  input  wire logic signed [31:0] in_feature_max_power,
  input  wire logic signed [31:0] in_feature_mean_power,
  input  wire logic signed [31:0] in_feature_variance,
  input  wire logic signed [31:0] in_feature_skewness,
  input  wire logic signed [31:0] in_feature_kurtosis,
  input  wire logic signed [31:0] in_feature_energy_ratio,
  input  wire logic signed [31:0] in_feature_peak_to_average,
  input  wire logic signed [31:0] in_feature_flatness,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_decision,
  output logic [15:0]             out_likelihood,
  output logic                    out_degenerate,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  cfg_t cfg;
  logic en;
  logic accept;
  logic [8:0] v_r;
  logic [31:0] mean_r [16];
  logic [39:0] ivar_r [16];
  word_vec_t feat;
  word_vec_t mean_n, mean_s;
  ivar_vec_t ivar_n, ivar_s;
  logic [46:0] acc_n, acc_s;
  logic [7:0][31:0] feat8;

  assign en = !(v_r[8] && out_stall);
  assign in_stall = !en;
  assign accept = in_valid && en;
  assign out_valid = v_r[8];

  assign feat8 = {in_feature_flatness, in_feature_peak_to_average,
                  in_feature_energy_ratio, in_feature_kurtosis,
                  in_feature_skewness, in_feature_variance,
                  in_feature_mean_power, in_feature_max_power};

  always_comb begin
    for (int d = 0; d < FeatureCount; d++) begin
      feat[d] = feat8[d & (Slots - 1)];
      mean_n[d] = mean_r[d & (Slots - 1)];
      mean_s[d] = mean_r[Slots + (d & (Slots - 1))];
      ivar_n[d] = ivar_r[d & (Slots - 1)];
      ivar_s[d] = ivar_r[Slots + (d & (Slots - 1))];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_command == CmdLoad) begin
      if (!in_param_index[4]) mean_r[in_param_index[3:0]] <= in_param_value[31:0];
      else ivar_r[in_param_index[3:0]] <= in_param_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:0], in_valid && in_command == CmdClassify};
    end
  end

  tgc_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  tgc_score u_score_noise (
    .clk(clk), .en(en), .feat(feat), .mean(mean_n), .ivar(ivar_n), .acc(acc_n)
  );

  tgc_score u_score_signal (
    .clk(clk), .en(en), .feat(feat), .mean(mean_s), .ivar(ivar_s), .acc(acc_s)
  );

  tgc_decide u_decide (
    .clk(clk), .en(en), .cfg(cfg), .acc_noise(acc_n), .acc_signal(acc_s),
    .decision(out_decision), .likelihood(out_likelihood),
    .degenerate(out_degenerate)
  );

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

  a_degenerate_is_noise: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (!out_decision && out_likelihood == 16'd0))
    else $error("degenerate result carries class or likelihood");

  a_signal_wins_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_decision) |-> out_likelihood[15])
    else $error("signal chosen with posterior below one half");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == CmdLoad) |=> !v_r[0])
    else $error("load item entered result pipeline");

endmodule
`default_nettype wire

/* hw/rtl/tgc_cfg.sv */
`default_nettype none
module tgc_cfg import tgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic [1:0] idx;
  logic wr;

  assign idx = paddr[4:3];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready <= 1'b0;
      cfg_r.bias_noise <= '0;
      cfg_r.bias_signal <= '0;
      cfg_r.log_floor <= FloorReset;
    end else if (wr) begin
      unique case (idx)
        RegReady:      cfg_r.ready <= pwdata[0];
        RegBiasNoise:  cfg_r.bias_noise <= pwdata[47:0];
        RegBiasSignal: cfg_r.bias_signal <= pwdata[47:0];
        RegLogFloor:   cfg_r.log_floor <= pwdata[47:0];
        default:       cfg_r.ready <= cfg_r.ready;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegReady:      prdata = {63'd0, cfg_r.ready};
      RegBiasNoise:  prdata = {{16{cfg_r.bias_noise[47]}}, cfg_r.bias_noise};
      RegBiasSignal: prdata = {{16{cfg_r.bias_signal[47]}}, cfg_r.bias_signal};
      RegLogFloor:   prdata = {{16{cfg_r.log_floor[47]}}, cfg_r.log_floor};
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/tgc_score.sv */
`default_nettype none
module tgc_score import tgc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire word_vec_t feat,
  input  wire word_vec_t mean,
  input  wire ivar_vec_t ivar,
  output logic [46:0]    acc
);

  logic signed [32:0] diff_r [FeatureCount];
  logic [39:0] iv1_r [FeatureCount];
  logic [65:0] sq_r [FeatureCount];
  logic [39:0] iv2_r [FeatureCount];
  logic [72:0] plo_r [FeatureCount];
  logic [72:0] phi_r [FeatureCount];
  logic [46:0] term_r [FeatureCount];
  logic [46:0] l1_r [4];
  logic [46:0] l2_r [2];
  logic [46:0] acc_r;

  logic [32:0] mag [FeatureCount];
  logic [105:0] prod [FeatureCount];
  logic [46:0] tv [8];

  always_comb begin
    for (int d = 0; d < FeatureCount; d++) begin
      mag[d] = diff_r[d][32] ? 33'(-diff_r[d]) : 33'(diff_r[d]);
      prod[d] = ({33'd0, phi_r[d]} << 33) + {33'd0, plo_r[d]};
    end
    for (int k = 0; k < 8; k++) begin
      tv[k] = (k < FeatureCount) ? term_r[k] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < FeatureCount; d++) begin
        diff_r[d] <= 33'($signed(feat[d])) - 33'($signed(mean[d]));
        iv1_r[d] <= ivar[d];
        sq_r[d] <= 66'(mag[d]) * 66'(mag[d]);
        iv2_r[d] <= iv1_r[d];
        plo_r[d] <= 73'(sq_r[d][32:0]) * 73'(iv2_r[d]);
        phi_r[d] <= 73'(sq_r[d][65:33]) * 73'(iv2_r[d]);
        term_r[d] <= (prod[d][105:ProdShift] > 74'(AccMax)) ? AccMax
                   : prod[d][ProdShift+46:ProdShift];
      end
      for (int k = 0; k < 4; k++) l1_r[k] <= sat_add(tv[2*k], tv[2*k+1]);
      for (int k = 0; k < 2; k++) l2_r[k] <= sat_add(l1_r[2*k], l1_r[2*k+1]);
      acc_r <= sat_add(l2_r[0], l2_r[1]);
    end
  end

  assign acc = acc_r;

endmodule
`default_nettype wire

/* hw/rtl/tgc_decide.sv */
`default_nettype none
module tgc_decide import tgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire cfg_t        cfg,
  input  wire logic [46:0] acc_noise,
  input  wire logic [46:0] acc_signal,
  output logic             decision,
  output logic [15:0]      likelihood,
  output logic             degenerate
);

  localparam sig_tab_t SigTab = build_sig();

  logic signed [47:0] sn_r, ss_r;
  logic cls_r;
  logic [15:0] lik_r;
  logic deg_r;

  logic signed [48:0] sn_w, ss_w;
  logic [48:0] gap;
  logic win;
  logic [IdxW-1:0] idx;
  logic over;

  always_comb begin
    sn_w = 49'(cfg.bias_noise) - 49'({1'b0, acc_noise[46:1]});
    ss_w = 49'(cfg.bias_signal) - 49'({1'b0, acc_signal[46:1]});
    win = ss_r > sn_r;
    gap = win ? 49'(49'(ss_r) - 49'(sn_r)) : 49'(49'(sn_r) - 49'(ss_r));
    idx = gap[IdxShift +: IdxW];
    over = (gap >> (IdxShift + IdxW)) != 49'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_r <= (sn_w < -49'sh800000000000) ? 48'sh800000000000 : sn_w[47:0];
      ss_r <= (ss_w < -49'sh800000000000) ? 48'sh800000000000 : ss_w[47:0];
      if (!cfg.ready) begin
        cls_r <= 1'b0;
        lik_r <= '0;
        deg_r <= 1'b0;
      end else if (sn_r < cfg.log_floor && ss_r < cfg.log_floor) begin
        cls_r <= 1'b0;
        lik_r <= '0;
        deg_r <= 1'b1;
      end else begin
        cls_r <= win;
        lik_r <= over ? 16'hFFFF : SigTab[idx];
        deg_r <= 1'b0;
      end
    end
  end

  assign decision = cls_r;
  assign likelihood = lik_r;
  assign degenerate = deg_r;

endmodule
`default_nettype wire
